[rtl/tppc_pkg.sv]
`default_nettype none

package tppc_pkg;

	localparam int TS_W           = 16;
	localparam int PHASE_W        = 2;
	localparam int PCT_W          = 7;
	localparam int CFG_IDX_W      = 2;
	localparam int RING_DEPTH_DEF = 4;
	localparam int PHASES_DEF     = 3;
	localparam int QUEUE_DEPTH    = 2;

	// deviation times 100 against average times percent
	localparam int SCALED_W = TS_W + PCT_W;

	// reset values of the registers
	localparam logic [PCT_W-1:0] RST_TOL_PCT  = 7'd25;
	localparam logic [PCT_W-1:0] RST_CONS_PCT = 7'd15;
	localparam logic [TS_W-1:0]  RST_MIN      = 16'd50;
	localparam logic [TS_W-1:0]  RST_MAX      = 16'd50000;
	localparam logic [PCT_W-1:0] PCT_SCALE    = 7'd100;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_TOL_PCT  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CONS_PCT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MIN      = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MAX      = 2'd3;

	// input commands
	localparam logic CMD_CAPTURE = 1'b0;
	localparam logic CMD_CLEAR   = 1'b1;

	// job kinds handed from front to back
	localparam logic [1:0] JOB_CLEAR = 2'd0;  // wipe all stores
	localparam logic [1:0] JOB_ADD   = 2'd1;  // store period, report phase
	localparam logic [1:0] JOB_LOOK  = 2'd2;  // no period, report phase
	localparam logic [1:0] JOB_NONE  = 2'd3;  // phase out of range

	// cross-phase divide by 2 or 3 as multiply and shift
	localparam int CONS_SUM_W = TS_W + 2;
	localparam int CONS_MUL_W = 20;
	localparam int CONS_SH    = 20;
	localparam int CONS_PROD_W = CONS_SUM_W + CONS_MUL_W;

	typedef struct packed {
		logic              cmd;
		logic [PHASE_W-1:0] phase;
		logic [TS_W-1:0]   timestamp;
	} item_t;

	typedef struct packed {
		logic [TS_W-1:0] phase_average_period;
		logic            phase_consistent;
		logic [TS_W-1:0] consensus_period;
		logic            measurement_ready;
		logic [1:0]      active_phases;
	} result_t;

	typedef struct packed {
		logic [PCT_W-1:0] tolerance_pct;
		logic [PCT_W-1:0] consensus_pct;
		logic [TS_W-1:0]  min_period;
		logic [TS_W-1:0]  max_period;
	} cfg_t;

	typedef struct packed {
		logic [1:0]         kind;
		logic [PHASE_W-1:0] phase;
		logic [TS_W-1:0]    period;
	} job_t;

	// reciprocal for dividing a sum of at most three averages by n of two or three
	function automatic logic [CONS_MUL_W-1:0] cons_recip(input logic [1:0] n);
		logic [CONS_MUL_W-1:0] r;
		unique case (n)
			2'd3: r = 20'd349526;
			2'd2: r = 20'd524288;
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

[rtl/tppc_ram.sv]
`default_nettype none

module tppc_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

[rtl/tppc_queue.sv]
`default_nettype none

module tppc_queue (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	output logic               full,
	input  wire tppc_pkg::job_t data_in,
	input  wire logic          pop,
	output logic               empty,
	output tppc_pkg::job_t     data_out
);
	import tppc_pkg::*;

	localparam int QW = $clog2(QUEUE_DEPTH);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	job_t          mem_q [QUEUE_DEPTH];
	logic [QW-1:0] wp_q;
	logic [QW-1:0] rp_q;
	logic [CW-1:0] cnt_q;
	logic          do_push;
	logic          do_pop;

	assign full     = (cnt_q == CW'(QUEUE_DEPTH));
	assign empty    = (cnt_q == '0);
	assign do_push  = push && !full;
	assign do_pop   = pop && !empty;
	assign data_out = mem_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wp_q <= (wp_q == QW'(QUEUE_DEPTH - 1)) ? '0 : wp_q + 1'b1;
			end
			if (do_pop) begin
				rp_q <= (rp_q == QW'(QUEUE_DEPTH - 1)) ? '0 : rp_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wp_q] <= data_in;
		end
	end

endmodule

`default_nettype wire

[rtl/tppc_front.sv]
`default_nettype none

module tppc_front #(
	parameter int PHASES = tppc_pkg::PHASES_DEF
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	output logic                full,
	input  wire tppc_pkg::item_t item,
	input  wire tppc_pkg::cfg_t  cfg,
	input  wire logic           q_full,
	output logic                q_push,
	output tppc_pkg::job_t      q_data
);
	import tppc_pkg::*;

	localparam int PH_IW = $clog2(PHASES);

	logic [TS_W-1:0]  last_q [PHASES];
	logic [PH_IW-1:0] ph_idx;
	logic             ph_ok;
	logic [TS_W-1:0]  last;
	logic [TS_W-1:0]  period;
	logic             in_window;

	assign full   = q_full;
	assign q_push = push && !q_full;
	assign ph_idx = item.phase[PH_IW-1:0];
	assign ph_ok  = (item.phase < PHASE_W'(PHASES));
	assign last   = last_q[ph_idx];
	// wraps modulo the timer width
	assign period = item.timestamp - last;
	assign in_window = (last != '0) && (period > cfg.min_period) && (period < cfg.max_period);

	always_comb begin
		q_data.phase  = item.phase;
		q_data.period = period;
		if (item.cmd == CMD_CLEAR) begin
			q_data.kind = JOB_CLEAR;
		end else if (!ph_ok) begin
			q_data.kind = JOB_NONE;
		end else if (in_window) begin
			q_data.kind = JOB_ADD;
		end else begin
			q_data.kind = JOB_LOOK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int p = 0; p < PHASES; p++) begin
				last_q[p] <= '0;
			end
		end else if (q_push) begin
			if (item.cmd == CMD_CLEAR) begin
				for (int p = 0; p < PHASES; p++) begin
					last_q[p] <= '0;
				end
			end else if (ph_ok) begin
				last_q[ph_idx] <= item.timestamp;
			end
		end
	end

endmodule

`default_nettype wire

[rtl/tppc_back.sv]
`default_nettype none

module tppc_back #(
	parameter int RING_DEPTH = tppc_pkg::RING_DEPTH_DEF,
	parameter int PHASES     = tppc_pkg::PHASES_DEF
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire tppc_pkg::cfg_t  cfg,
	input  wire logic           q_empty,
	output logic                q_pop,
	input  wire tppc_pkg::job_t  q_data,
	output logic                empty,
	input  wire logic           pop,
	output tppc_pkg::result_t   result
);
	import tppc_pkg::*;

	localparam int PH_IW  = $clog2(PHASES);
	localparam int IW     = $clog2(RING_DEPTH);
	localparam int FW     = $clog2(RING_DEPTH + 1);
	localparam int RAM_D  = PHASES << IW;
	localparam int AW     = $clog2(RAM_D);
	localparam int SUM_W  = TS_W + IW;
	localparam int AVG_SH = SUM_W + IW;
	localparam int AM_W   = SUM_W + 1;
	localparam int PROD_W = SUM_W + AM_W;
	localparam longint unsigned AVG_MUL_L =
		((64'd1 << AVG_SH) + RING_DEPTH - 1) / RING_DEPTH;
	localparam logic [AM_W-1:0] AVG_MUL = AM_W'(AVG_MUL_L);

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_ADD  = 4'd1;
	localparam logic [3:0] ST_SCAN = 4'd2;
	localparam logic [3:0] ST_DIV  = 4'd3;
	localparam logic [3:0] ST_TOL  = 4'd4;
	localparam logic [3:0] ST_C0   = 4'd5;
	localparam logic [3:0] ST_C1   = 4'd6;
	localparam logic [3:0] ST_C2   = 4'd7;
	localparam logic [3:0] ST_C3   = 4'd8;
	localparam logic [3:0] ST_C4   = 4'd9;
	localparam logic [3:0] ST_FIN  = 4'd10;

	logic [3:0]       state_q;
	job_t             job_q;
	logic [IW-1:0]    ptr_q   [PHASES];
	logic [FW-1:0]    fill_q  [PHASES];
	logic [TS_W-1:0]  avg_q   [PHASES];
	logic             ok_q    [PHASES];
	logic [TS_W-1:0]  hold_q;
	logic             out_vld_q;
	result_t          out_q;

	// scan control
	logic [FW-1:0]    cnt_q;
	logic             pass_q;
	logic             rv_q;
	logic             rl_q;
	logic             bad_q;

	// arithmetic payload
	logic [SUM_W-1:0]       acc_q;
	logic [PROD_W-1:0]      prod_q;
	logic [SCALED_W-1:0]    tol_q;
	logic [PHASES-1:0]      sel_q;
	logic [1:0]             n_q;
	logic [CONS_SUM_W-1:0]  csum_q;
	logic [CONS_PROD_W-1:0] cprod_q;
	logic [TS_W-1:0]        mean_q;
	logic [SCALED_W-1:0]    ctol_q;
	logic [CONS_SUM_W-1:0]  asum_q;
	logic [1:0]             acnt_q;
	logic [CONS_PROD_W-1:0] aprod_q;

	logic [PH_IW-1:0] ph_idx;
	logic             ram_we;
	logic [AW-1:0]    ram_waddr;
	logic [AW-1:0]    ram_raddr;
	logic [TS_W-1:0]  ram_rdata;
	logic             issue;
	logic [TS_W-1:0]  avg_cur;
	logic [TS_W-1:0]  diff_r;
	logic             bad_now;
	logic [TS_W-1:0]  avg_new;
	logic [TS_W-1:0]  mean_new;
	logic [PHASES-1:0]     sel_c;
	logic [1:0]            n_c;
	logic [CONS_SUM_W-1:0] csum_c;
	logic [CONS_SUM_W-1:0] asum_c;
	logic [1:0]            acnt_c;
	logic [TS_W-1:0]       adiff;
	logic [TS_W-1:0]  hold_new;
	logic             ready_new;
	logic             out_wr;
	result_t          out_d;

	assign ph_idx    = job_q.phase[PH_IW-1:0];
	assign ram_we    = (state_q == ST_ADD);
	assign ram_waddr = {ph_idx, ptr_q[ph_idx]};
	assign ram_raddr = {ph_idx, cnt_q[IW-1:0]};
	assign issue     = (cnt_q != FW'(RING_DEPTH));
	assign avg_cur   = avg_q[ph_idx];
	assign diff_r    = (ram_rdata >= avg_cur) ? ram_rdata - avg_cur : avg_cur - ram_rdata;
	assign bad_now   = (SCALED_W'(diff_r) * SCALED_W'(PCT_SCALE)) > tol_q;
	assign avg_new   = prod_q[AVG_SH +: TS_W];
	assign mean_new  = cprod_q[CONS_SH +: TS_W];
	assign q_pop     = (state_q == ST_IDLE) && !q_empty;
	assign out_wr    = (state_q == ST_FIN) && (!out_vld_q || pop);
	assign empty     = !out_vld_q;
	assign result    = out_q;

	tppc_ram #(
		.WIDTH(TS_W),
		.DEPTH(RAM_D)
	) u_ring (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(job_q.period),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// full and consistent phases
	always_comb begin
		n_c    = '0;
		csum_c = '0;
		for (int p = 0; p < PHASES; p++) begin
			sel_c[p] = ok_q[p] && (fill_q[p] == FW'(RING_DEPTH));
			if (sel_c[p]) begin
				n_c    = n_c + 2'd1;
				csum_c = csum_c + CONS_SUM_W'(avg_q[p]);
			end
		end
	end

	// phases that agree with the cross-phase mean
	always_comb begin
		acnt_c = '0;
		asum_c = '0;
		adiff  = '0;
		for (int p = 0; p < PHASES; p++) begin
			adiff = (avg_q[p] >= mean_q) ? avg_q[p] - mean_q : mean_q - avg_q[p];
			if (sel_q[p] &&
				((SCALED_W'(adiff) * SCALED_W'(PCT_SCALE)) <= ctol_q)) begin
				acnt_c = acnt_c + 2'd1;
				asum_c = asum_c + CONS_SUM_W'(avg_q[p]);
			end
		end
	end

	always_comb begin
		hold_new  = hold_q;
		ready_new = 1'b0;
		if (n_q == 2'd1) begin
			hold_new  = csum_q[TS_W-1:0];
			ready_new = 1'b1;
		end else if (n_q >= 2'd2 && acnt_q >= 2'd2) begin
			hold_new  = aprod_q[CONS_SH +: TS_W];
			ready_new = 1'b1;
		end
		out_d.consensus_period  = hold_new;
		out_d.measurement_ready = ready_new;
		out_d.active_phases     = n_q;
		if (job_q.kind == JOB_ADD || job_q.kind == JOB_LOOK) begin
			out_d.phase_average_period = avg_cur;
			out_d.phase_consistent     = ok_q[ph_idx];
		end else begin
			out_d.phase_average_period = '0;
			out_d.phase_consistent     = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			hold_q    <= '0;
			out_vld_q <= 1'b0;
			cnt_q     <= '0;
			pass_q    <= 1'b0;
			rv_q      <= 1'b0;
			rl_q      <= 1'b0;
			bad_q     <= 1'b0;
			for (int p = 0; p < PHASES; p++) begin
				ptr_q[p]  <= '0;
				fill_q[p] <= '0;
				avg_q[p]  <= '0;
				ok_q[p]   <= 1'b0;
			end
		end else begin
			if (out_wr) begin
				out_vld_q <= 1'b1;
			end else if (pop) begin
				out_vld_q <= 1'b0;
			end
			rv_q <= (state_q == ST_SCAN) && issue;
			rl_q <= (state_q == ST_SCAN) && (cnt_q == FW'(RING_DEPTH - 1));
			unique case (state_q)
				ST_IDLE: begin
					if (q_pop) begin
						if (q_data.kind == JOB_CLEAR) begin
							hold_q <= '0;
							for (int p = 0; p < PHASES; p++) begin
								ptr_q[p]  <= '0;
								fill_q[p] <= '0;
								avg_q[p]  <= '0;
								ok_q[p]   <= 1'b0;
							end
						end
						state_q <= (q_data.kind == JOB_ADD) ? ST_ADD : ST_C0;
					end
				end
				ST_ADD: begin
					ptr_q[ph_idx] <= (ptr_q[ph_idx] == IW'(RING_DEPTH - 1)) ?
						'0 : ptr_q[ph_idx] + 1'b1;
					if (fill_q[ph_idx] != FW'(RING_DEPTH)) begin
						fill_q[ph_idx] <= fill_q[ph_idx] + 1'b1;
					end
					if (fill_q[ph_idx] >= FW'(RING_DEPTH - 1)) begin
						state_q <= ST_SCAN;
						cnt_q   <= '0;
						pass_q  <= 1'b0;
					end else begin
						state_q <= ST_C0;
					end
				end
				ST_SCAN: begin
					if (issue) begin
						cnt_q <= cnt_q + 1'b1;
					end
					if (rv_q) begin
						bad_q <= bad_q | bad_now;
					end
					if (rv_q && rl_q) begin
						if (pass_q) begin
							ok_q[ph_idx] <= !(bad_q | bad_now);
							state_q      <= ST_C0;
						end else begin
							state_q <= ST_DIV;
						end
					end
				end
				ST_DIV: begin
					state_q <= ST_TOL;
				end
				ST_TOL: begin
					avg_q[ph_idx] <= avg_new;
					state_q       <= ST_SCAN;
					cnt_q         <= '0;
					pass_q        <= 1'b1;
					bad_q         <= 1'b0;
				end
				ST_C0: state_q <= ST_C1;
				ST_C1: state_q <= ST_C2;
				ST_C2: state_q <= ST_C3;
				ST_C3: state_q <= ST_C4;
				ST_C4: state_q <= ST_FIN;
				ST_FIN: begin
					if (out_wr) begin
						hold_q  <= hold_new;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (q_pop) begin
			job_q <= q_data;
		end
		if (state_q == ST_ADD) begin
			acc_q <= '0;
		end else if (state_q == ST_SCAN && rv_q && !pass_q) begin
			acc_q <= acc_q + SUM_W'(ram_rdata);
		end
		if (state_q == ST_DIV) begin
			prod_q <= PROD_W'(acc_q) * PROD_W'(AVG_MUL);
		end
		if (state_q == ST_TOL) begin
			tol_q <= SCALED_W'(avg_new) * SCALED_W'(cfg.tolerance_pct);
		end
		if (state_q == ST_C0) begin
			sel_q  <= sel_c;
			n_q    <= n_c;
			csum_q <= csum_c;
		end
		if (state_q == ST_C1) begin
			cprod_q <= CONS_PROD_W'(csum_q) * CONS_PROD_W'(cons_recip(n_q));
		end
		if (state_q == ST_C2) begin
			mean_q <= mean_new;
			ctol_q <= SCALED_W'(mean_new) * SCALED_W'(cfg.consensus_pct);
		end
		if (state_q == ST_C3) begin
			asum_q <= asum_c;
			acnt_q <= acnt_c;
		end
		if (state_q == ST_C4) begin
			aprod_q <= CONS_PROD_W'(asum_q) * CONS_PROD_W'(cons_recip(acnt_q));
		end
		if (out_wr) begin
			out_q <= out_d;
		end
	end

`ifndef SYNTHESIS
	a_clear_result: assert property (@(posedge clk) disable iff (!arst_n)
		(out_wr && job_q.kind == JOB_CLEAR) |->
		(out_d.active_phases == 2'd0 && out_d.consensus_period == '0 &&
		 !out_d.measurement_ready))
		else $error("clear beat left measurement state behind");

	a_ready_active: assert property (@(posedge clk) disable iff (!arst_n)
		(out_wr && out_d.measurement_ready) |-> (out_d.active_phases != 2'd0))
		else $error("ready reported with no active phase");

	a_one_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_wr |=> (state_q == ST_IDLE && out_vld_q))
		else $error("result beat not followed by idle with result held");

	a_read_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		rv_q |-> $past(state_q == ST_SCAN))
		else $error("ring data valid without a scan read");
`endif

endmodule

`default_nettype wire

[rtl/three_phase_period_consensus.sv]
`default_nettype none

// Zero-crossing period consensus for up to three motor phases. Each input beat is a capture
// (phase, 16-bit timer stamp) or a clear; each produces exactly one result beat, in order,
// with the addressed phase's average period and consistency flag, the held consensus period,
// the ready flag and the count of full, consistent phases. A stamp of zero marks "no previous
// capture", so it forms no period and the next capture on that phase starts fresh. The front
// end takes a beat in every cycle that full is low, forms the wrapped period against the last
// stamp of that phase, checks the min/max window and queues a job in a two-entry queue. The
// back end runs one job at a time on a sequencer: a capture that fills or refreshes a full
// ring walks its RING_DEPTH entries (four by default) twice, one entry a cycle (sum, then
// tolerance check); a capture that leaves the ring not yet full only stores its period, and
// neither it nor a clear or a dropped capture walks the ring at all. Divides by the ring
// depth and by two or three are done as registered multiplies by a reciprocal; percentage
// limits are checked as deviation*100 against average*percent, with no divider at all. A
// finished result waits in the output register while the back end starts on the next job.
// Registers (index: tolerance_pct 0, consensus_pct 1, min_period 2, max_period 3) are written
// through the cfg port, which is always ready, and should only be written while no beat is
// in flight.
module three_phase_period_consensus #(
	parameter int RING_DEPTH = tppc_pkg::RING_DEPTH_DEF,
	parameter int PHASES     = tppc_pkg::PHASES_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	// capture side
	input  wire logic                              push,
	output logic                                   full,
	input  wire tppc_pkg::item_t                   item,
	// result side
	output logic                                   empty,
	input  wire logic                              pop,
	output tppc_pkg::result_t                      result,
	// register writes
	input  wire logic                              cfg_valid,
	output logic                                   cfg_ready,
	input  wire logic [tppc_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [tppc_pkg::TS_W-1:0]         cfg_data
);
	import tppc_pkg::*;

	cfg_t cfg_q;
	logic q_push;
	logic q_full;
	job_t q_wdata;
	logic q_pop;
	logic q_empty;
	job_t q_rdata;

	// register file, write beats land immediately
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.tolerance_pct <= RST_TOL_PCT;
			cfg_q.consensus_pct <= RST_CONS_PCT;
			cfg_q.min_period    <= RST_MIN;
			cfg_q.max_period    <= RST_MAX;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_TOL_PCT:  cfg_q.tolerance_pct <= cfg_data[PCT_W-1:0];
				REG_CONS_PCT: cfg_q.consensus_pct <= cfg_data[PCT_W-1:0];
				REG_MIN:      cfg_q.min_period    <= cfg_data;
				REG_MAX:      cfg_q.max_period    <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// front: last stamp per phase, period and window check
	tppc_front #(
		.PHASES(PHASES)
	) u_front (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.full  (full),
		.item  (item),
		.cfg   (cfg_q),
		.q_full(q_full),
		.q_push(q_push),
		.q_data(q_wdata)
	);

	// decouples capture acceptance from the back-end sequencer
	tppc_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (q_push),
		.full    (q_full),
		.data_in (q_wdata),
		.pop     (q_pop),
		.empty   (q_empty),
		.data_out(q_rdata)
	);

	// back: ring store, averaging, consistency and consensus
	tppc_back #(
		.RING_DEPTH(RING_DEPTH),
		.PHASES    (PHASES)
	) u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.q_empty(q_empty),
		.q_pop  (q_pop),
		.q_data (q_rdata),
		.empty  (empty),
		.pop    (pop),
		.result (result)
	);

endmodule

`default_nettype wire
